FILE: hdl/pearson_template_matcher_assert.svh
// Assertion macros for the Pearson template matcher.
// Included by the back end, which checks its own control logic.
`ifndef PEARSON_TEMPLATE_MATCHER_ASSERT_SVH
`define PEARSON_TEMPLATE_MATCHER_ASSERT_SVH

// same-cycle implication
`define PTM_ASSERT_IMPLY(label, clk, rstn, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
    else $error("ptm assertion failed");

// next-cycle implication
`define PTM_ASSERT_NEXT(label, clk, rstn, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
    else $error("ptm assertion failed");

`endif

FILE: hdl/ptm_pkg.sv
// Shared types and constants of the Pearson template matcher.
// No dependencies; used by every module of the block.
package ptm_pkg;

  localparam int unsigned MAX_TAPS_DFLT    = 16;
  localparam int unsigned SAMPLE_BITS_DFLT = 16;
  localparam int unsigned INDEX_BITS_DFLT  = 16;

  localparam int unsigned TL_W       = 5;
  localparam int unsigned THR_W      = 16;
  localparam int unsigned TAP_W      = 4;
  localparam int unsigned VAL_W      = 16;
  localparam int unsigned WIN_IDX_W  = 16;
  localparam int unsigned CORR_W     = 16;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;

  localparam int unsigned Q_BITS           = 15;
  localparam int unsigned Q_FRAC           = 14;
  localparam int unsigned CORR_ONE         = 16384;
  localparam int unsigned CORR_SCALE_SHIFT = 30;
  localparam int unsigned MUL_DIGIT_BITS   = 8;

  localparam logic [CFG_IDX_W-1:0] REG_TEMPLATE_LENGTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD       = 1'b1;

  localparam logic ACT_LOAD   = 1'b0;
  localparam logic ACT_SAMPLE = 1'b1;

  localparam logic [TL_W-1:0] TL_RESET = 5'd16;

  typedef struct packed {
    logic                    action;
    logic [TAP_W-1:0]        tap_index;
    logic signed [VAL_W-1:0] sample_value;
  } in_item_t;

  typedef struct packed {
    logic [WIN_IDX_W-1:0]     window_index;
    logic signed [CORR_W-1:0] correlation;
  } out_item_t;

  typedef enum logic [1:0] {
    OP_LOAD,
    OP_RESTART,
    OP_SAMPLE
  } op_kind_e;

  typedef struct packed {
    op_kind_e         kind;
    logic [TAP_W-1:0] tap;
    logic [VAL_W-1:0] value;
  } op_t;

endpackage

FILE: hdl/ptm_front.sv
// Front end of the matcher: input queue that classifies each item on entry.
// Depends on ptm_pkg.
module ptm_front #(
  parameter int unsigned MAX_TAPS = ptm_pkg::MAX_TAPS_DFLT
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  output logic              full_o,
  input  ptm_pkg::in_item_t item_i,
  output logic              op_valid_o,
  input  logic              op_ready_i,
  output ptm_pkg::op_t      op_o
);
  import ptm_pkg::*;

  localparam int unsigned Depth = 2;

  op_t        ent_q [Depth];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  op_t        op_new;
  logic       do_push, do_pop;

  always_comb begin
    op_new.tap   = item_i.tap_index;
    op_new.value = $unsigned(item_i.sample_value);
    if (item_i.action == ACT_SAMPLE) begin
      op_new.kind = OP_SAMPLE;
    end else if (int'(item_i.tap_index) < int'(MAX_TAPS)) begin
      op_new.kind = OP_LOAD;
    end else begin
      op_new.kind = OP_RESTART;
    end
  end

  assign full_o     = (cnt_q == 2'(Depth));
  assign op_valid_o = (cnt_q != 2'd0);
  assign op_o       = ent_q[rd_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = op_valid_o && op_ready_i;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      ent_q[wr_q] <= op_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_push) begin
        wr_q <= ~wr_q;
      end
      if (do_pop) begin
        rd_q <= ~rd_q;
      end
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

FILE: hdl/ptm_mul.sv
// Digit-serial unsigned multiplier, one 8-bit digit of b per cycle.
// Depends on ptm_pkg; used by the back end for all wide products.
module ptm_mul #(
  parameter int unsigned MW = 42
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [MW-1:0]   a_i,
  input  logic [MW-1:0]   b_i,
  output logic            done_o,
  output logic [2*MW-1:0] prod_o
);
  import ptm_pkg::*;

  localparam int unsigned PW = 2 * MW;

  logic          busy_q, done_q;
  logic [PW-1:0] acc_q, a_q;
  logic [MW-1:0] b_q;
  logic [PW-1:0] part;

  assign part   = a_q * PW'(b_q[MUL_DIGIT_BITS-1:0]);
  assign done_o = done_q;
  assign prod_o = acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      acc_q  <= '0;
      a_q    <= '0;
      b_q    <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        acc_q  <= '0;
        a_q    <= PW'(a_i);
        b_q    <= b_i;
      end else if (busy_q) begin
        if (b_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          acc_q <= acc_q + part;
          a_q   <= a_q << MUL_DIGIT_BITS;
          b_q   <= b_q >> MUL_DIGIT_BITS;
        end
      end
    end
  end

endmodule

FILE: hdl/ptm_back.sv
// Back end: template store, sample window, window sums and the exact
// correlation search. Depends on ptm_pkg, ptm_mul and the assertion header.
`include "pearson_template_matcher_assert.svh"

module ptm_back #(
  parameter int unsigned MAX_TAPS    = ptm_pkg::MAX_TAPS_DFLT,
  parameter int unsigned SAMPLE_BITS = ptm_pkg::SAMPLE_BITS_DFLT,
  parameter int unsigned INDEX_BITS  = ptm_pkg::INDEX_BITS_DFLT
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              op_valid_i,
  output logic                              op_ready_o,
  input  ptm_pkg::op_t                      op_i,
  input  logic [ptm_pkg::TL_W-1:0]          tl_i,
  input  logic signed [ptm_pkg::THR_W-1:0]  thr_i,
  output logic                              res_valid_o,
  output ptm_pkg::out_item_t                res_item_o,
  input  logic                              res_pop_i
);
  import ptm_pkg::*;

  localparam int unsigned S   = SAMPLE_BITS;
  localparam int unsigned LW  = $clog2(MAX_TAPS + 1);
  localparam int unsigned TIW = $clog2(MAX_TAPS);
  localparam int unsigned XW  = S + LW;
  localparam int unsigned QW  = 2 * S + LW;
  localparam int unsigned MW  = 2 * S + 2 * LW;
  localparam int unsigned NW  = MW + 1;
  localparam int unsigned PW  = 2 * MW;
  localparam int unsigned CW  = PW + 33;

  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_XX, S_HH, S_XH, S_MSTART, S_MWAIT, S_Q0, S_Q1, S_Q2, S_OUT
  } state_e;

  typedef enum logic [2:0] {
    MS_LXH, MS_SXSH, MS_LXX, MS_SXSX, MS_LHH, MS_SHSH, MS_VV, MS_NN
  } mstep_e;

  state_e                 state_q;
  mstep_e                 mstep_q;
  logic signed [S-1:0]    win_q [MAX_TAPS];
  logic signed [S-1:0]    tmpl_mem [MAX_TAPS];
  logic signed [S-1:0]    x_q, h_q;
  logic [LW-1:0]          fill_q, len_q;
  logic [TIW-1:0]         i_q;
  logic [INDEX_BITS-1:0]  wcnt_q, idx_q;
  logic signed [XW-1:0]   sx_q, sh_q;
  logic signed [QW-1:0]   sxx_q, shh_q, sxh_q;
  logic signed [NW-1:0]   num_q, vx_q, vh_q;
  logic [PW-1:0]          p_q;
  logic [CW-1:0]          r_q, e_q, t_q, qp4_q;
  logic [Q_BITS-1:0]      q_q;
  logic [3:0]             k_q;
  logic                   out_valid_q;
  out_item_t              out_item_q;

  logic [LW-1:0]          len_cfg, fill_nx;
  logic signed [S-1:0]    v_in;
  logic [TIW-1:0]         widx;
  logic                   tmpl_we;
  logic signed [S-1:0]    ma, mb;
  logic signed [2*S-1:0]  mp;
  logic [MW-1:0]          sx_mag, sh_mag, sxh_mag, num_mag, mul_a, mul_b;
  logic                   mul_start, mul_done;
  logic [PW-1:0]          mul_prod;
  logic signed [NW-1:0]   prod_s, vh_fin;
  logic [CW-1:0]          p_ext, t2;
  logic [4:0]             sh1, sh2;
  logic signed [CORR_W-1:0] corr;

  always_comb begin
    if (tl_i == '0) begin
      len_cfg = LW'(1);
    end else if (int'(tl_i) > int'(MAX_TAPS)) begin
      len_cfg = LW'(MAX_TAPS);
    end else begin
      len_cfg = LW'(tl_i);
    end
    fill_nx = (int'(fill_q) < int'(MAX_TAPS)) ? fill_q + LW'(1) : fill_q;
  end

  assign v_in    = $signed(S'(op_i.value));
  assign widx    = TIW'(int'(MAX_TAPS) - int'(len_q) + int'(i_q));
  assign tmpl_we = (state_q == S_IDLE) && op_valid_i && (op_i.kind == OP_LOAD);

  assign ma = (state_q == S_HH) ? h_q : x_q;
  assign mb = (state_q == S_XX) ? x_q : h_q;
  assign mp = ma * mb;

  assign sx_mag  = sx_q[XW-1]   ? MW'(-sx_q)  : MW'(sx_q);
  assign sh_mag  = sh_q[XW-1]   ? MW'(-sh_q)  : MW'(sh_q);
  assign sxh_mag = sxh_q[QW-1]  ? MW'(-sxh_q) : MW'(sxh_q);
  assign num_mag = num_q[NW-1]  ? MW'(-num_q) : MW'(num_q);

  always_comb begin
    case (mstep_q)
      MS_LXH:  begin mul_a = sxh_mag;      mul_b = MW'(len_q); end
      MS_SXSH: begin mul_a = sx_mag;       mul_b = sh_mag;     end
      MS_LXX:  begin mul_a = MW'(sxx_q);   mul_b = MW'(len_q); end
      MS_SXSX: begin mul_a = sx_mag;       mul_b = sx_mag;     end
      MS_LHH:  begin mul_a = MW'(shh_q);   mul_b = MW'(len_q); end
      MS_SHSH: begin mul_a = sh_mag;       mul_b = sh_mag;     end
      MS_VV:   begin mul_a = MW'(vx_q);    mul_b = MW'(vh_q);  end
      MS_NN:   begin mul_a = num_mag;      mul_b = num_mag;    end
      default: begin mul_a = '0;           mul_b = '0;         end
    endcase
  end

  assign mul_start = (state_q == S_MSTART);

  ptm_mul #(
    .MW(MW)
  ) u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(mul_start),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .done_o (mul_done),
    .prod_o (mul_prod)
  );

  assign prod_s = $signed(NW'(mul_prod));
  assign vh_fin = vh_q - prod_s;

  assign p_ext = CW'(p_q);
  assign sh1   = {1'b0, k_q} + 5'd2;
  assign sh2   = {k_q, 1'b0} + 5'd2;
  assign t2    = t_q - (p_ext << sh1);
  assign corr  = num_q[NW-1] ? -$signed({1'b0, q_q}) : $signed({1'b0, q_q});

  assign op_ready_o  = (state_q == S_IDLE);
  assign res_valid_o = out_valid_q;
  assign res_item_o  = out_item_q;

  always_ff @(posedge clk_i) begin
    if (tmpl_we) begin
      tmpl_mem[TIW'(op_i.tap)] <= v_in;
    end
    h_q <= tmpl_mem[i_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mstep_q     <= MS_LXH;
      for (int j = 0; j < int'(MAX_TAPS); j++) begin
        win_q[j] <= '0;
      end
      x_q         <= '0;
      fill_q      <= '0;
      len_q       <= '0;
      i_q         <= '0;
      wcnt_q      <= '0;
      idx_q       <= '0;
      sx_q        <= '0;
      sh_q        <= '0;
      sxx_q       <= '0;
      shh_q       <= '0;
      sxh_q       <= '0;
      num_q       <= '0;
      vx_q        <= '0;
      vh_q        <= '0;
      p_q         <= '0;
      r_q         <= '0;
      e_q         <= '0;
      t_q         <= '0;
      qp4_q       <= '0;
      q_q         <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
      out_item_q  <= '0;
    end else begin
      if (res_pop_i && out_valid_q) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (op_valid_i) begin
            case (op_i.kind)
              OP_LOAD, OP_RESTART: begin
                fill_q <= '0;
                wcnt_q <= '0;
              end
              OP_SAMPLE: begin
                for (int j = 0; j < int'(MAX_TAPS) - 1; j++) begin
                  win_q[j] <= win_q[j+1];
                end
                win_q[MAX_TAPS-1] <= v_in;
                fill_q <= fill_nx;
                if (fill_nx >= len_cfg) begin
                  idx_q   <= wcnt_q;
                  wcnt_q  <= wcnt_q + INDEX_BITS'(1);
                  len_q   <= len_cfg;
                  i_q     <= '0;
                  sx_q    <= '0;
                  sh_q    <= '0;
                  sxx_q   <= '0;
                  shh_q   <= '0;
                  sxh_q   <= '0;
                  mstep_q <= MS_LXH;
                  state_q <= S_RD;
                end
              end
              default: ;
            endcase
          end
        end
        S_RD: begin
          x_q     <= win_q[widx];
          state_q <= S_XX;
        end
        S_XX: begin
          sxx_q   <= sxx_q + QW'(mp);
          sx_q    <= sx_q + XW'(x_q);
          sh_q    <= sh_q + XW'(h_q);
          state_q <= S_HH;
        end
        S_HH: begin
          shh_q   <= shh_q + QW'(mp);
          state_q <= S_XH;
        end
        S_XH: begin
          sxh_q <= sxh_q + QW'(mp);
          if (int'(i_q) == int'(len_q) - 1) begin
            state_q <= S_MSTART;
          end else begin
            i_q     <= i_q + TIW'(1);
            state_q <= S_RD;
          end
        end
        S_MSTART: begin
          state_q <= S_MWAIT;
        end
        S_MWAIT: begin
          if (mul_done) begin
            state_q <= S_MSTART;
            case (mstep_q)
              MS_LXH: begin
                num_q   <= sxh_q[QW-1] ? -prod_s : prod_s;
                mstep_q <= MS_SXSH;
              end
              MS_SXSH: begin
                num_q   <= (sx_q[XW-1] ^ sh_q[XW-1]) ? num_q + prod_s : num_q - prod_s;
                mstep_q <= MS_LXX;
              end
              MS_LXX: begin
                vx_q    <= prod_s;
                mstep_q <= MS_SXSX;
              end
              MS_SXSX: begin
                vx_q    <= vx_q - prod_s;
                mstep_q <= MS_LHH;
              end
              MS_LHH: begin
                vh_q    <= prod_s;
                mstep_q <= MS_SHSH;
              end
              MS_SHSH: begin
                vh_q    <= vh_fin;
                mstep_q <= MS_VV;
                if (vx_q <= 0 || vh_fin <= 0) begin
                  state_q <= S_IDLE;
                end
              end
              MS_VV: begin
                p_q     <= mul_prod;
                mstep_q <= MS_NN;
              end
              MS_NN: begin
                r_q     <= CW'(mul_prod) << CORR_SCALE_SHIFT;
                e_q     <= p_ext;
                qp4_q   <= '0;
                q_q     <= '0;
                k_q     <= 4'(Q_FRAC);
                state_q <= S_Q0;
              end
              default: state_q <= S_IDLE;
            endcase
          end
        end
        S_Q0: begin
          t_q     <= e_q + (qp4_q << (k_q + 4'd1));
          state_q <= S_Q1;
        end
        S_Q1: begin
          t_q     <= t_q + (p_ext << sh2);
          state_q <= S_Q2;
        end
        S_Q2: begin
          if (t2 <= r_q) begin
            e_q      <= t2;
            qp4_q    <= qp4_q + (p_ext << sh1);
            q_q[k_q] <= 1'b1;
          end
          if (k_q == 4'd0) begin
            state_q <= S_OUT;
          end else begin
            k_q     <= k_q - 4'd1;
            state_q <= S_Q0;
          end
        end
        S_OUT: begin
          if (corr <= thr_i) begin
            state_q <= S_IDLE;
          end else if (!out_valid_q) begin
            out_item_q.window_index <= WIN_IDX_W'(idx_q);
            out_item_q.correlation  <= corr;
            out_valid_q             <= 1'b1;
            state_q                 <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  `PTM_ASSERT_IMPLY(a_fill_sat, clk_i, rst_ni, 1'b1, int'(fill_q) <= int'(MAX_TAPS))
  `PTM_ASSERT_IMPLY(a_k_range, clk_i, rst_ni, state_q == S_Q0 || state_q == S_Q1 || state_q == S_Q2, k_q <= 4'(Q_FRAC))
  `PTM_ASSERT_IMPLY(a_q_bound, clk_i, rst_ni, state_q == S_OUT, int'(q_q) <= int'(CORR_ONE))
  `PTM_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_q && !res_pop_i, out_valid_q && $stable(out_item_q))

endmodule

FILE: hdl/pearson_template_matcher.sv
// Top level of the Pearson template matcher: configuration registers,
// front-end queue and back-end engine. Depends on ptm_pkg, ptm_front, ptm_back.
//
//   port group              direction  transfer when
//   push / full / in_item_i  in         push && !full
//   empty / pop / out_item_o out        pop && !empty
//   cfg_we_i / idx / data    in         cfg_we_i
//
// Load item, or a sample that completes no window: handled in S_IDLE alone. Window:
// sums per tap through S_RD, S_XX, S_HH, S_XH on one multiplier, then 8 serial
// products on ptm_mul (six if a variance is not positive), then an exact search,
// one quotient bit per pass through S_Q0, S_Q1, S_Q2. Two items queue up front;
// one result waits out. Reset is asynchronous, active low, and needs no clearing pass.
module pearson_template_matcher #(
  parameter int unsigned MAX_TAPS    = ptm_pkg::MAX_TAPS_DFLT,
  parameter int unsigned SAMPLE_BITS = ptm_pkg::SAMPLE_BITS_DFLT,
  parameter int unsigned INDEX_BITS  = ptm_pkg::INDEX_BITS_DFLT
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              push,
  output logic                              full,
  input  ptm_pkg::in_item_t                 in_item_i,
  output logic                              empty,
  input  logic                              pop,
  output ptm_pkg::out_item_t                out_item_o,
  input  logic                              cfg_we_i,
  input  logic [ptm_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [ptm_pkg::CFG_DATA_W-1:0]    cfg_data_i
);
  import ptm_pkg::*;

  logic [TL_W-1:0]          tl_q;
  logic signed [THR_W-1:0]  thr_q;
  logic                     op_valid, op_ready, res_valid;
  op_t                      op;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tl_q  <= TL_RESET;
      thr_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_TEMPLATE_LENGTH: tl_q  <= cfg_data_i[TL_W-1:0];
        REG_THRESHOLD:       thr_q <= $signed(cfg_data_i[THR_W-1:0]);
        default: ;
      endcase
    end
  end

  ptm_front #(
    .MAX_TAPS(MAX_TAPS)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .full_o    (full),
    .item_i    (in_item_i),
    .op_valid_o(op_valid),
    .op_ready_i(op_ready),
    .op_o      (op)
  );

  ptm_back #(
    .MAX_TAPS   (MAX_TAPS),
    .SAMPLE_BITS(SAMPLE_BITS),
    .INDEX_BITS (INDEX_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_valid_i (op_valid),
    .op_ready_o (op_ready),
    .op_i       (op),
    .tl_i       (tl_q),
    .thr_i      (thr_q),
    .res_valid_o(res_valid),
    .res_item_o (out_item_o),
    .res_pop_i  (pop)
  );

  assign empty = !res_valid;

endmodule
